// ===== src/dhsp_pkg.sv =====
// Shared types and constants for the double hash server placement unit.
package dhsp_pkg;

  localparam int MAX_SERVERS = 64;
  localparam int MAX_SLOTS   = 16;
  localparam int MAX_PROBES  = 64;

  localparam int KEY_W   = 8;
  localparam int SRV_W   = 6;
  localparam int FILL_W  = 5;
  localparam int SCNT_W  = 7;
  localparam int SLOT_W  = 5;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int REM_W   = $clog2(MAX_SERVERS + 1);
  localparam int PROBE_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

  // The step term reaches 255 * 104729 + 123, which needs 25 bits.
  localparam int DIV_W     = 25;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] HASH_MUL_A = DIV_W'(7919);
  localparam logic [DIV_W-1:0] HASH_MUL_B = DIV_W'(104729);
  localparam logic [DIV_W-1:0] HASH_ADD_B = DIV_W'(123);

  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_SERVER = CFG_IDX_W'(1);

  localparam logic [SCNT_W-1:0] SERVER_COUNT_RST = SCNT_W'(64);
  localparam logic [SLOT_W-1:0] SLOTS_RST        = SLOT_W'(16);

  typedef struct packed {
    logic [KEY_W-1:0] request_byte;
    logic             last_byte;
  } req_beat_t;

  typedef struct packed {
    logic [SRV_W-1:0]  chosen_server;
    logic [SRV_W-1:0]  home_server;
    logic              redirected;
    logic              placement_failed;
    logic [FILL_W-1:0] fill_after;
  } res_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK
  } state_e;

endpackage

// ===== src/dhsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dhsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dhsp_hash.sv =====
// Hash unit: forms the base and step terms of a key and reduces both modulo the server count.
module dhsp_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dhsp_pkg::KEY_W-1:0]   key_i,
  input  logic [dhsp_pkg::REM_W-1:0]   modulus_i,
  output logic                         done_o,
  output logic [dhsp_pkg::REM_W-1:0]   base_mod_o,
  output logic [dhsp_pkg::REM_W-1:0]   step_mod_o
);
  import dhsp_pkg::*;

  logic [DIV_W-1:0]     base_q, base_d;
  logic [DIV_W-1:0]     step_q, step_d;
  logic [REM_W-1:0]     rem_a_q, rem_a_d;
  logic [REM_W-1:0]     rem_b_q, rem_b_d;
  logic [REM_W-1:0]     mod_q, mod_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [REM_W:0]       shift_a, shift_b;

  // One dividend bit per cycle, MSB first; the partial remainder stays below the modulus.
  always_comb begin
    shift_a = {rem_a_q, base_q[DIV_W-1]};
    shift_b = {rem_b_q, step_q[DIV_W-1]};
    if (shift_a >= {1'b0, mod_q}) begin
      shift_a = shift_a - {1'b0, mod_q};
    end
    if (shift_b >= {1'b0, mod_q}) begin
      shift_b = shift_b - {1'b0, mod_q};
    end
  end

  always_comb begin
    base_d  = base_q;
    step_d  = step_q;
    rem_a_d = rem_a_q;
    rem_b_d = rem_b_q;
    mod_d   = mod_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (start_i) begin
      base_d  = DIV_W'(key_i) * HASH_MUL_A;
      step_d  = DIV_W'(key_i) * HASH_MUL_B + HASH_ADD_B;
      rem_a_d = '0;
      rem_b_d = '0;
      mod_d   = modulus_i;
      cnt_d   = DIV_CNT_W'(DIV_W - 1);
      run_d   = 1'b1;
    end else if (run_q) begin
      base_d  = base_q << 1;
      step_d  = step_q << 1;
      rem_a_d = shift_a[REM_W-1:0];
      rem_b_d = shift_b[REM_W-1:0];
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    step_q  <= step_d;
    rem_a_q <= rem_a_d;
    rem_b_q <= rem_b_d;
    mod_q   <= mod_d;
  end

  assign done_o     = done_q;
  assign base_mod_o = rem_a_q;
  assign step_mod_o = rem_b_q;

endmodule

// ===== src/double_hash_server_placement_unit.sv =====
// Key bytes are taken one per cycle while busy is low; a non-final byte gives no result.
// A final byte raises busy: its hash terms load at that edge, the hash unit reduces them,
// the first probe loads, and each probe reads the occupancy RAM in ST_READ and checks in ST_CHECK.
// The result strobes after the ST_CHECK of the placing probe, or of the last of 64 probes.
// Reset clears the key, restores the register defaults and clears a valid flag per server,
// so all occupancies read as zero at once. The receiver cannot stall.
module double_hash_server_placement_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  dhsp_pkg::req_beat_t               req_i,
  output logic                              done_o,
  output dhsp_pkg::res_beat_t               res_o,
  input  logic                              cfg_we_i,
  input  logic [dhsp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dhsp_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import dhsp_pkg::*;

  state_e state_q, state_d;

  logic [SCNT_W-1:0]  server_count_q;
  logic [SLOT_W-1:0]  slots_q;
  logic [KEY_W-1:0]   xor_q;
  logic [REM_W-1:0]   n_eff;
  logic [SLOT_W-1:0]  cap_eff;

  logic               accept;
  logic               hash_start;
  logic [KEY_W-1:0]   key;
  logic               hash_done;
  logic [REM_W-1:0]   base_mod, step_mod;

  logic [REM_W-1:0]   srv_q, step_q;
  logic [SRV_W-1:0]   home_q;
  logic [PROBE_W-1:0] probe_q;
  logic [MAX_SERVERS-1:0] valid_q;

  logic [REM_W:0]     srv_sum;
  logic [REM_W-1:0]   srv_next;
  logic [SRV_W-1:0]   ram_addr;
  logic [SLOT_W-1:0]  ram_rdata;
  logic [SLOT_W-1:0]  occ;
  logic               fits;
  logic               last_probe;
  logic               ram_re, ram_we;
  logic [SLOT_W-1:0]  ram_wdata;

  logic               done_q, done_d;
  res_beat_t          res_q, res_d;

  // Effective register values, clamped into their legal ranges.
  always_comb begin
    if (server_count_q == '0) begin
      n_eff = REM_W'(1);
    end else if (REM_W'(server_count_q) > REM_W'(MAX_SERVERS)) begin
      n_eff = REM_W'(MAX_SERVERS);
    end else begin
      n_eff = REM_W'(server_count_q);
    end
    if (slots_q == '0) begin
      cap_eff = SLOT_W'(1);
    end else if (slots_q > SLOT_W'(MAX_SLOTS)) begin
      cap_eff = SLOT_W'(MAX_SLOTS);
    end else begin
      cap_eff = slots_q;
    end
  end

  assign accept     = start && (state_q == ST_IDLE);
  assign key        = xor_q ^ req_i.request_byte;
  assign hash_start = accept && req_i.last_byte;

  dhsp_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (hash_start),
    .key_i      (key),
    .modulus_i  (n_eff),
    .done_o     (hash_done),
    .base_mod_o (base_mod),
    .step_mod_o (step_mod)
  );

  // Next probe: both terms are below the modulus, so one subtract wraps the sum.
  always_comb begin
    srv_sum = {1'b0, srv_q} + {1'b0, step_q};
    if (srv_sum >= {1'b0, n_eff}) begin
      srv_sum = srv_sum - {1'b0, n_eff};
    end
    srv_next = srv_sum[REM_W-1:0];
  end

  assign ram_addr   = srv_q[SRV_W-1:0];
  assign occ        = valid_q[ram_addr] ? ram_rdata : '0;
  assign fits       = occ < cap_eff;
  assign last_probe = probe_q == PROBE_W'(MAX_PROBES - 1);

  dhsp_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SERVERS)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (hash_start) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (fits || last_probe) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: RAM access and the result beat.
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = occ + 1'b1;
    done_d    = 1'b0;
    res_d     = res_q;
    case (state_q)
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_CHECK: begin
        if (fits) begin
          ram_we                 = 1'b1;
          done_d                 = 1'b1;
          res_d.chosen_server    = ram_addr;
          res_d.home_server      = home_q;
          res_d.redirected       = probe_q != '0;
          res_d.placement_failed = 1'b0;
          res_d.fill_after       = FILL_W'(occ + 1'b1);
        end else if (last_probe) begin
          done_d                 = 1'b1;
          res_d.chosen_server    = '0;
          res_d.home_server      = home_q;
          res_d.redirected       = 1'b0;
          res_d.placement_failed = 1'b1;
          res_d.fill_after       = '0;
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      server_count_q <= SERVER_COUNT_RST;
      slots_q        <= SLOTS_RST;
      xor_q          <= '0;
      valid_q        <= '0;
      done_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SERVER_COUNT:     server_count_q <= cfg_wdata_i[SCNT_W-1:0];
          CFG_SLOTS_PER_SERVER: slots_q        <= cfg_wdata_i[SLOT_W-1:0];
          default:              slots_q        <= slots_q;
        endcase
      end
      if (accept) begin
        xor_q <= req_i.last_byte ? '0 : key;
      end
      if (ram_we) begin
        valid_q[ram_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == ST_HASH && hash_done) begin
      srv_q   <= base_mod;
      step_q  <= step_mod;
      home_q  <= base_mod[SRV_W-1:0];
      probe_q <= '0;
    end else if (state_q == ST_CHECK && !fits && !last_probe) begin
      srv_q   <= srv_next;
      probe_q <= probe_q + 1'b1;
    end
  end

  assign busy   = state_q != ST_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
